[rtl/sem_pkg.sv]
// Shared widths, register indexes, reset values and handshake structs for the Sobel block.
package sem_pkg;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 13;
   localparam int HEIGHT_REG_W = 16;
   localparam int THRESH_W     = 11;
   localparam int MAG_W        = 11;
   localparam int ROW_W        = 16;
   localparam int CENTER_COL_W = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [THRESH_W-1:0]     THRESH_RESET = 11'd0;

   // gradients span -1020..1020
   localparam int GRAD_W = 11;
   // gx^2 + gy^2 < 2^21, padded to an even width for two bits per step
   localparam int RAD_W      = 22;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sem_root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sem_root_rsp_type;

endpackage

[rtl/sem_req_if.sv]
// Pixel input channel: valid, ready and one grayscale pixel.
interface sem_req_if
   import sem_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

[rtl/sem_rsp_if.sv]
// Result channel: valid, ready and one edge magnitude with its position.
interface sem_rsp_if
   import sem_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [MAG_W-1:0]        edge_magnitude;
   logic [ROW_W-1:0]        center_row;
   logic [CENTER_COL_W-1:0] center_col;
   logic                    frame_last;

   modport source (output valid, output edge_magnitude, output center_row,
                   output center_col, output frame_last, input ready);
   modport sink   (input valid, input edge_magnitude, input center_row,
                   input center_col, input frame_last, output ready);
endinterface

[rtl/sem_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sem_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle, rounded to nearest.
module sem_sqrt
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  sem_root_req_type req,
   output sem_root_rsp_type rsp
);

   logic [RAD_W-1:0]      rad_ff;
   logic [ROOT_W:0]       rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [ROOT_CNT_W-1:0] count_ff;
   logic                  active_ff;
   logic                  done_ff;

   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic              take;

   // partial remainder shifted in with the next bit pair, against 4*root+1
   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (req.start) begin
         active_ff <= 1'b1;
         done_ff   <= 1'b0;
         count_ff  <= ROOT_CNT_W'(ROOT_W);
      end else if (active_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == ROOT_CNT_W'(1)) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rad_ff  <= req.radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (active_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= (ROOT_W+1)'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= (ROOT_W+1)'(rem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // remainder above the floor root means the value is past the halfway point
   assign rsp.done = done_ff;
   assign rsp.root = root_ff + ROOT_W'((ROOT_W+1)'(root_ff) < rem_ff);

endmodule

[rtl/sobel_edge_magnitude_threshold.sv]
// Top level: streaming Sobel 3x3 gradient magnitude with threshold over two line RAMs.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+----------------------------------------------
//  req     | in  | valid/ready      | pixel_value[7:0]
//  rsp     | out | valid/ready      | edge_magnitude[10:0], center_row, center_col,
//          |     |                  | frame_last
//  csr     | in  | csr_write_enable | csr_index selects width, height, threshold
//
// A border pixel is accepted, then read from the line RAMs and written back.
// An interior pixel goes through accept, RAM read with gradient, square and sum,
// the bit-serial square root, one iteration per root bit, then the load of the
// output register.
// Reset clears the counters, window and FSM; line RAM contents stay undefined.
// A full output register holds the finished word and keeps the FSM in ROOT; the
// next pixel is taken as soon as the FSM is back in idle.
module sobel_edge_magnitude_threshold
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   sem_req_if.sink               req,
   sem_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (EW_W > WIDTH_REG_W) ? EW_W : WIDTH_REG_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_SQUARE = 2'd2;
   localparam logic [1:0] ST_ROOT   = 2'd3;

   // config registers
   logic [WIDTH_REG_W-1:0]  frame_width_ff;
   logic [HEIGHT_REG_W-1:0] frame_height_ff;
   logic [THRESH_W-1:0]     edge_threshold_ff;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [PIX_W-1:0] win_ff [6];   // [0..2] oldest column, [3..5] previous column

   // per-word payload
   logic [PIX_W-1:0]        bot_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [ROW_W-1:0]        res_row_ff;
   logic [CENTER_COL_W-1:0] res_col_ff;
   logic                    res_last_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [MAG_W-1:0]        rsp_mag_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [CENTER_COL_W-1:0] rsp_col_ff;
   logic                    rsp_last_ff;

   logic                    req_fire;
   logic                    rsp_load;
   logic [PIX_W-1:0]        top_pix, mid_pix;
   logic [EW_W-1:0]         eff_w;
   logic [ROW_W-1:0]        eff_h;
   logic [CMP_W-1:0]        fw_ext;
   logic [EW_W-1:0]         col_ext, col_inc;
   logic [ROW_W:0]          row_inc;
   logic                    has_result;
   logic [COL_W-1:0]        col_m1;
   logic signed [GRAD_W-1:0] gx_in, gy_in;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   sem_root_req_type        root_req;
   sem_root_rsp_type        root_rsp;

   function automatic logic signed [GRAD_W-1:0] sx(input logic [PIX_W-1:0] p);
      return signed'({{(GRAD_W-PIX_W){1'b0}}, p});
   endfunction

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= WIDTH_RESET;
         frame_height_ff   <= HEIGHT_RESET;
         edge_threshold_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_data[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_data[HEIGHT_REG_W-1:0];
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp width into 3..MAX_WIDTH, height to at least 3
   assign fw_ext = CMP_W'(frame_width_ff);
   always_comb begin
      if (fw_ext < CMP_W'(3)) begin
         eff_w = EW_W'(3);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = EW_W'(fw_ext);
      end
   end
   assign eff_h = (frame_height_ff < ROW_W'(3)) ? ROW_W'(3) : frame_height_ff;

   // ---------------- line RAMs ----------------
   // read at the column on accept; data arrives in READ, where both rows
   // shift down one line and are written back at the same column.
   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (col_ff),
      .wr_data (mid_pix),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (top_pix)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (col_ff),
      .wr_data (bot_ff),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (mid_pix)
   );

   // ---------------- position ----------------
   assign col_ext    = EW_W'(col_ff);
   assign col_inc    = col_ext + 1'b1;
   assign row_inc    = {1'b0, row_ff} + 1'b1;
   assign col_m1     = col_ff - 1'b1;
   assign has_result = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2)) &&
                       (col_ext < eff_w) && (row_ff < eff_h);

   // ---------------- gradients ----------------
   always_comb begin
      gx_in = (sx(top_pix) - sx(win_ff[0])) +
              ((sx(mid_pix) - sx(win_ff[1])) <<< 1) +
              (sx(bot_ff) - sx(win_ff[2]));
      gy_in = (sx(win_ff[2]) + (sx(win_ff[5]) <<< 1) + sx(bot_ff)) -
              (sx(win_ff[0]) + (sx(win_ff[3]) <<< 1) + sx(top_pix));
   end

   assign gx_sq             = gx_ff * gx_ff;
   assign gy_sq             = gy_ff * gy_ff;
   assign root_req.start    = (state_ff == ST_SQUARE);
   assign root_req.radicand = RAD_W'($unsigned(gx_sq)) + RAD_W'($unsigned(gy_sq));

   sem_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   // ---------------- sequencer ----------------
   assign rsp_load = (state_ff == ST_ROOT) && root_rsp.done &&
                     (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = has_result ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_READ) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_pix;
            win_ff[4] <= mid_pix;
            win_ff[5] <= bot_ff;
            if (col_inc >= eff_w) begin
               col_ff <= '0;
               row_ff <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
            end else begin
               col_ff <= col_inc[COL_W-1:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         bot_ff <= req.pixel_value;
      end
      if (state_ff == ST_READ) begin
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         res_row_ff  <= row_ff - 1'b1;
         res_col_ff  <= CENTER_COL_W'(col_m1);
         res_last_ff <= (row_ff == eff_h - 1'b1) && (col_ext == eff_w - 1'b1);
      end
      if (rsp_load) begin
         rsp_mag_ff  <= (root_rsp.root > edge_threshold_ff) ? root_rsp.root : '0;
         rsp_row_ff  <= res_row_ff;
         rsp_col_ff  <= res_col_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.edge_magnitude = rsp_mag_ff;
   assign rsp.center_row     = rsp_row_ff;
   assign rsp.center_col     = rsp_col_ff;
   assign rsp.frame_last     = rsp_last_ff;

endmodule

[rtl/sem_checker.sv]
// Port-level checks for the Sobel block, bound onto the top level.
module sem_checker
   import sem_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [MAG_W-1:0]        edge_magnitude,
   input logic [ROW_W-1:0]        center_row,
   input logic [CENTER_COL_W-1:0] center_col,
   input logic                    frame_last
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(edge_magnitude) &&
         $stable(center_row) && $stable(center_col) && $stable(frame_last))
      else $error("result word changed while stalled");

   // one pixel in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pixel accepted while previous one still in progress");

   // a result needs read, square and root stages after its pixel
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready, 1) &&
         !$past(req_valid && req_ready, 2))
      else $error("result appeared too soon after a pixel");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sobel_edge_magnitude_threshold sem_checker u_sem_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .edge_magnitude (rsp.edge_magnitude),
   .center_row     (rsp.center_row),
   .center_col     (rsp.center_col),
   .frame_last     (rsp.frame_last)
);

[tb/sv/sobel_edge_magnitude_threshold_tb.sv]
// Self-checking testbench for the streaming Sobel edge magnitude block.
module sobel_edge_magnitude_threshold_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sem_pkg::*;

   localparam int LINE_DEPTH   = 4096;
   localparam int RANDOM_ITEMS = 600;
   // first-row stretch run at the clamped widest width
   localparam int WIDE_ITEMS   = 120;
   // generous drain margin for a pixel still in flight
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int MAX_GAP       = 19;

   // one result word as it leaves the block
   typedef struct packed {
      logic [MAG_W-1:0]        edge_magnitude;
      logic [ROW_W-1:0]        center_row;
      logic [CENTER_COL_W-1:0] center_col;
      logic                    frame_last;
   } edge_word_type;

   // directed row: pixel, and optionally a hand-written expected word
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             typed;
      edge_word_type    word;
   } stim_row_type;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_BINARY,
      STYLE_RAMP,
      STYLE_NEAR_RAIL
   } pix_style_type;

   // Three 3x3 frames. Vertical edge (left 0, right 255, middle column
   // matched top and bottom so gy cancels) gives 1020; horizontal edge the
   // same; the last frame repeats the vertical edge at threshold 1020, which
   // is not above it and so reads 0.
   localparam stim_row_type DIRECTED [27] = '{
      {8'd0,   1'b0, 40'd0}, {8'd200, 1'b0, 40'd0}, {8'd255, 1'b0, 40'd0},
      {8'd0,   1'b0, 40'd0}, {8'd10,  1'b0, 40'd0}, {8'd255, 1'b0, 40'd0},
      {8'd0,   1'b0, 40'd0}, {8'd200, 1'b0, 40'd0},
      {8'd255, 1'b1, 11'd1020, 16'd1, 12'd1, 1'b1},
      {8'd0,   1'b0, 40'd0}, {8'd0,   1'b0, 40'd0}, {8'd0,   1'b0, 40'd0},
      {8'd77,  1'b0, 40'd0}, {8'd77,  1'b0, 40'd0}, {8'd77,  1'b0, 40'd0},
      {8'd255, 1'b0, 40'd0}, {8'd255, 1'b0, 40'd0},
      {8'd255, 1'b1, 11'd1020, 16'd1, 12'd1, 1'b1},
      {8'd0,   1'b0, 40'd0}, {8'd128, 1'b0, 40'd0}, {8'd255, 1'b0, 40'd0},
      {8'd0,   1'b0, 40'd0}, {8'd1,   1'b0, 40'd0}, {8'd255, 1'b0, 40'd0},
      {8'd0,   1'b0, 40'd0}, {8'd128, 1'b0, 40'd0},
      {8'd255, 1'b1, 11'd0, 16'd1, 12'd1, 1'b1}
   };
   localparam int THRESH_SWITCH_ROW = 18;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sem_req_if pix_if ();
   sem_rsp_if edge_if ();

   sobel_edge_magnitude_threshold #(
      .MAX_WIDTH (LINE_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req              (pix_if.sink),
      .rsp              (edge_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow of the block: registers, line stores, window, counters
   // ---------------------------------------------------------------
   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;
   logic [THRESH_W-1:0]     cfg_threshold;
   logic [PIX_W-1:0]        upper_line  [LINE_DEPTH];
   logic [PIX_W-1:0]        middle_line [LINE_DEPTH];
   // [0..2] oldest column top/mid/bottom, [3..5] previous column
   logic [PIX_W-1:0]        win [6];
   int                      col_count;
   int                      row_count;

   edge_word_type edges_due [$];   // words the block still owes, oldest first
   int            error_count = 0;
   int            items_sent  = 0;
   int            cycle_count = 0;
   bit            req_idling  = 1'b1;
   bit            rsp_idling  = 1'b1;

   function automatic int active_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      return (cfg_height < 3) ? 3 : int'(cfg_height);
   endfunction

   // floor root bit by bit, then round: up when s - q*q exceeds q
   function automatic int unsigned rounded_root(input int unsigned s);
      int unsigned q;
      int unsigned t;
      q = 0;
      for (int b = 11; b >= 0; b--) begin
         t = q | (32'd1 << b);
         if (t * t <= s) q = t;
      end
      if (s - q * q > q) q++;
      return q;
   endfunction

   // Advances the shadow by one pixel; returns 1 with the word when the
   // pixel completes an interior window.
   function automatic bit sobel_window_step(input logic [PIX_W-1:0] pix,
                                            output edge_word_type word);
      int          w, h, c, r, idx;
      int          p00, p10, p20, p01, p21, p02, p12, p22;
      int          gx, gy;
      int unsigned root;
      logic [PIX_W-1:0] top, mid;
      bit          hit;
      w    = active_width();
      h    = active_height();
      c    = col_count;
      r    = row_count;
      idx  = c % LINE_DEPTH;
      top  = upper_line[idx];
      mid  = middle_line[idx];
      hit  = 1'b0;
      word = '0;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
         p00 = win[0]; p10 = win[1]; p20 = win[2];
         p01 = win[3]; p21 = win[5];
         p02 = top;    p12 = mid;    p22 = pix;
         gx = (p02 - p00) + 2 * (p12 - p10) + (p22 - p20);
         gy = (p20 + 2 * p21 + p22) - (p00 + 2 * p01 + p02);
         root = rounded_root(gx * gx + gy * gy);
         word.edge_magnitude = (root > cfg_threshold) ? root[MAG_W-1:0] : '0;
         word.center_row     = ROW_W'(r - 1);
         word.center_col     = CENTER_COL_W'(c - 1);
         word.frame_last     = (r == h - 1) && (c == w - 1);
         hit = 1'b1;
      end
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = top;    win[4] = mid;    win[5] = pix;
      upper_line[idx]  = mid;
      middle_line[idx] = pix;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_count = c;
      row_count = r;
      return hit;
   endfunction

   function automatic logic [PIX_W-1:0] pixel_for(input pix_style_type style, input int r,
                                                  input int c);
      case (style)
         STYLE_UNIFORM: return PIX_W'($urandom_range(0, 255));
         STYLE_BINARY:  return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         // smooth ramp that wraps now and then, plus a little noise
         STYLE_RAMP:    return PIX_W'(r * 17 + c * 29 + $urandom_range(0, 7));
         default:       return PIX_W'(($urandom_range(0, 1) ? 252 : 0) + $urandom_range(0, 3));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width     = data[WIDTH_REG_W-1:0];
         CSR_FRAME_HEIGHT:   cfg_height    = data[HEIGHT_REG_W-1:0];
         CSR_EDGE_THRESHOLD: cfg_threshold = data[THRESH_W-1:0];
         default: ;
      endcase
   endtask

   // One pixel word: optional gap, then hold valid until ready. The shadow
   // advances at the accepting edge; a typed row overrides the prediction.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit use_typed,
                             input edge_word_type typed_word);
      int            gap;
      edge_word_type word;
      gap = req_idling ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         pix_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_if.valid       <= 1'b1;
      pix_if.pixel_value <= pix;
      do @(posedge clock); while (!pix_if.ready);
      items_sent++;
      if (sobel_window_step(pix, word)) edges_due.push_back(use_typed ? typed_word : word);
   endtask

   // Runs the stream up to the next frame start (a whole frame from 0,0).
   task automatic feed_frame(input pix_style_type style);
      do send_pixel(pixel_for(style, row_count, col_count), 1'b0, '0);
      while (col_count != 0 || row_count != 0);
   endtask

   // Block idle: every word back, then room for a border pixel in flight.
   task automatic settle();
      pix_if.valid <= 1'b0;
      while (edges_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Result side: random backpressure, in-order compare
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   initial begin : drain
      int            stall;
      edge_word_type got;
      edge_word_type want;
      edge_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idling ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            edge_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         edge_if.ready <= 1'b1;
         do @(posedge clock); while (!edge_if.valid);
         got.edge_magnitude = edge_if.edge_magnitude;
         got.center_row     = edge_if.center_row;
         got.center_col     = edge_if.center_col;
         got.frame_last     = edge_if.frame_last;
         if (edges_due.size() == 0) begin
            error_count++;
            $display("%0t ns: word with nothing pending, actual mag %0d row %0d col %0d last %0d",
                     $time, got.edge_magnitude, got.center_row, got.center_col,
                     got.frame_last);
         end else begin
            want = edges_due.pop_front();
            check_field("edge_magnitude", want.edge_magnitude, got.edge_magnitude);
            check_field("center_row", want.center_row, got.center_row);
            check_field("center_col", want.center_col, got.center_col);
            check_field("frame_last", want.frame_last, got.frame_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      int            w, h, frames, base;
      pix_style_type style;
      pix_if.valid       = 1'b0;
      pix_if.pixel_value = '0;
      // shadow after reset; line stores are zero here but never read for
      // a result before they are written
      cfg_width     = WIDTH_RESET;
      cfg_height    = HEIGHT_RESET;
      cfg_threshold = THRESH_RESET;
      col_count     = 0;
      row_count     = 0;
      for (int i = 0; i < 6; i++) win[i] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: width and height below range both act as 3
      csr_write(CSR_FRAME_WIDTH, 16'd0);
      csr_write(CSR_FRAME_HEIGHT, 16'd0);
      csr_write(CSR_EDGE_THRESHOLD, 16'd0);
      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (i == THRESH_SWITCH_ROW) begin
            settle();
            csr_write(CSR_EDGE_THRESHOLD, 16'd1020);
         end
         send_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].word);
      end

      // Width above range clamps to the line depth: a stretch of the first
      // row with no idling on either side, which stays silent.
      settle();
      csr_write(CSR_FRAME_WIDTH, 16'h1FFF);
      csr_write(CSR_FRAME_HEIGHT, 16'd3);
      csr_write(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 400)));
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      repeat (WIDE_ITEMS) send_pixel(pixel_for(STYLE_UNIFORM, row_count, col_count), 1'b0, '0);

      // Narrow width with tallest height and top threshold: the column count
      // sits past the new width, so the first pixel is silent and opens the
      // next row. Then shrink both mid-frame: the row count is already past
      // the new height, so the rest of the row is silent and the counters
      // wrap to a fresh frame.
      settle();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      csr_write(CSR_FRAME_WIDTH, 16'd8);
      csr_write(CSR_FRAME_HEIGHT, 16'hFFFF);
      csr_write(CSR_EDGE_THRESHOLD, 16'd2047);
      repeat (43) send_pixel(pixel_for(STYLE_UNIFORM, row_count, col_count), 1'b0, '0);
      settle();
      csr_write(CSR_FRAME_WIDTH, 16'd5);
      csr_write(CSR_FRAME_HEIGHT, 16'd3);
      csr_write(CSR_EDGE_THRESHOLD, 16'd0);
      feed_frame(STYLE_BINARY);
      feed_frame(STYLE_BINARY);
      feed_frame(STYLE_NEAR_RAIL);

      // Random phases: mostly narrow short frames, each phase its own
      // geometry, threshold, idling mix and picture content.
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
         csr_write(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
         csr_write(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
         case ($urandom_range(0, 4))
            0:       csr_write(CSR_EDGE_THRESHOLD, 16'd0);
            1:       csr_write(CSR_EDGE_THRESHOLD, 16'd2047);
            2:       csr_write(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 2047)));
            default: csr_write(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 700)));
         endcase
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            style = pix_style_type'($urandom_range(0, 3));
            feed_frame(style);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
